### design/simv_pressure_breath_cycler_defines.svh
`ifndef SIMV_PRESSURE_BREATH_CYCLER_DEFINES_SVH
`define SIMV_PRESSURE_BREATH_CYCLER_DEFINES_SVH
// implication check with reset disable
`define SPBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbl failed");
// next-cycle implication check
`define SPBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbl failed");
`endif

### design/spbc_pkg.sv
package spbc_pkg;
  localparam int TIMER_BITS = 16;
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_EXH = 3'd1;
  localparam logic [2:0] PH_MAND_TRIG = 3'd2;
  localparam logic [2:0] PH_SUPPORT = 3'd3;
  localparam logic [2:0] PH_MAND_CTRL = 3'd4;
  localparam logic [2:0] PH_APNEA_INSP = 3'd5;
  localparam logic [2:0] PH_APNEA_EXH = 3'd6;
  localparam logic [2:0] PH_OTHER = 3'd7;
  localparam logic [1:0] KIND_ASSIST = 2'd0;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_SUPPORT = 2'd2;
  localparam logic [1:0] HIST_SUPPORT = 2'd0;
  localparam logic [1:0] HIST_TRIG = 2'd1;
  localparam logic [1:0] HIST_CTRL = 2'd2;
  localparam logic [1:0] START_NONE = 2'd0;
  localparam logic [1:0] START_PAT = 2'd1;
  localparam logic [1:0] START_MACH = 2'd2;
  localparam logic [1:0] END_TIMED = 2'd0;
  localparam logic [1:0] END_HP = 2'd1;
  localparam logic [1:0] END_FLOW = 2'd2;
  localparam logic [2:0] REG_CONTROL_RATE = 3'd0;
  localparam logic [2:0] REG_BACKUP_RATE = 3'd1;
  localparam logic [2:0] REG_INSP_TIME = 3'd2;
  localparam logic [2:0] REG_START_DELAY = 3'd3;
  localparam logic [2:0] REG_APNEA_EXIT = 3'd4;
  localparam logic [15:0] PERIOD_RESET = 16'd5000;

  // 60000 / rate for every 6-bit rate, highest rate first, zero rate as one
  localparam logic [63:0][15:0] PERIOD_TAB = {
    16'd952,   16'd967,   16'd983,   16'd1000,  16'd1016,  16'd1034,  16'd1052,  16'd1071,
    16'd1090,  16'd1111,  16'd1132,  16'd1153,  16'd1176,  16'd1200,  16'd1224,  16'd1250,
    16'd1276,  16'd1304,  16'd1333,  16'd1363,  16'd1395,  16'd1428,  16'd1463,  16'd1500,
    16'd1538,  16'd1578,  16'd1621,  16'd1666,  16'd1714,  16'd1764,  16'd1818,  16'd1875,
    16'd1935,  16'd2000,  16'd2068,  16'd2142,  16'd2222,  16'd2307,  16'd2400,  16'd2500,
    16'd2608,  16'd2727,  16'd2857,  16'd3000,  16'd3157,  16'd3333,  16'd3529,  16'd3750,
    16'd4000,  16'd4285,  16'd4615,  16'd5000,  16'd5454,  16'd6000,  16'd6666,  16'd7500,
    16'd8571,  16'd10000, 16'd12000, 16'd15000, 16'd20000, 16'd30000, 16'd60000, 16'd60000
  };

  typedef struct packed {
    logic       insp_trigger;
    logic       exp_trigger;
    logic       high_pressure;
    logic       apnea_alarm;
    logic [15:0] support_ti_min;
    logic [15:0] support_ti_max;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  breath_start;
    logic [2:0]  phase_now;
    logic [1:0]  cycle_kind;
    logic        apnea_controlled;
    logic [15:0] ti_measured;
    logic [15:0] te_measured;
    logic        history_written;
    logic [1:0]  history_kind;
    logic        support_end_written;
    logic [1:0]  support_end_cause;
    logic        apnea_restart;
  } out_word_t;

  typedef struct packed {
    logic [15:0] normal_period;
    logic [15:0] backup_period;
    logic [15:0] insp_time_ms;
    logic [15:0] start_delay_ms;
    logic [1:0]  apnea_exit_triggers;
  } cfg_t;

  // look up 60000 / rate, zero rate as one
  function automatic logic [15:0] period_of(input logic [5:0] rate);
    return PERIOD_TAB[rate];
  endfunction
endpackage

### design/spbc_stream_if.sv
interface spbc_in_if;
  logic valid;
  logic ready;
  spbc_pkg::in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spbc_out_if;
  logic valid;
  logic ready;
  spbc_pkg::out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### design/spbc_cfg_regs.sv
module spbc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output spbc_pkg::cfg_t    cfg
);
  logic [5:0]  ctrl_rate_r;
  logic [5:0]  back_rate_r;
  logic [15:0] norm_per_r;
  logic [15:0] back_per_r;
  logic [15:0] insp_r;
  logic [15:0] delay_r;
  logic [1:0]  exit_r;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_rate_r <= 6'd12;
      back_rate_r <= 6'd12;
      norm_per_r <= spbc_pkg::PERIOD_RESET;
      back_per_r <= spbc_pkg::PERIOD_RESET;
      insp_r <= 16'd1000;
      delay_r <= 16'd2000;
      exit_r <= 2'd2;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        spbc_pkg::REG_CONTROL_RATE: begin
          ctrl_rate_r <= pwdata[5:0];
          norm_per_r <= spbc_pkg::period_of(pwdata[5:0]);
        end
        spbc_pkg::REG_BACKUP_RATE: begin
          back_rate_r <= pwdata[5:0];
          back_per_r <= spbc_pkg::period_of(pwdata[5:0]);
        end
        spbc_pkg::REG_INSP_TIME: insp_r <= pwdata[15:0];
        spbc_pkg::REG_START_DELAY: delay_r <= pwdata[15:0];
        spbc_pkg::REG_APNEA_EXIT: exit_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      spbc_pkg::REG_CONTROL_RATE: prdata = {26'd0, ctrl_rate_r};
      spbc_pkg::REG_BACKUP_RATE: prdata = {26'd0, back_rate_r};
      spbc_pkg::REG_INSP_TIME: prdata = {16'd0, insp_r};
      spbc_pkg::REG_START_DELAY: prdata = {16'd0, delay_r};
      spbc_pkg::REG_APNEA_EXIT: prdata = {30'd0, exit_r};
      default: prdata = 32'd0;
    endcase
  end

  assign cfg.normal_period = norm_per_r;
  assign cfg.backup_period = back_per_r;
  assign cfg.insp_time_ms = insp_r;
  assign cfg.start_delay_ms = delay_r;
  assign cfg.apnea_exit_triggers = exit_r;
endmodule

### design/spbc_seq.sv
module spbc_seq #(
  parameter int RING_DEPTH = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  spbc_pkg::in_word_t   din,
  input  spbc_pkg::cfg_t       cfg,
  output spbc_pkg::out_word_t  dout
);
  localparam int TIMER_BITS = spbc_pkg::TIMER_BITS;
  localparam int SW = $clog2(RING_DEPTH);
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam int DW = TIMER_BITS + 2;

  logic [2:0] phase_r, phase_nxt;
  logic first_r, first_nxt, sup_seen_r, sup_seen_nxt, delayed_r, delayed_nxt;
  logic canc_r, canc_nxt, te_done_r, te_done_nxt;
  logic [TIMER_BITS-1:0] ic_r, ic_nxt, ec_r, ec_nxt, pc_r, pc_nxt;
  logic [TIMER_BITS-1:0] mark_r, mark_nxt, lti_r, lti_nxt, lte_r, lte_nxt;
  logic [1:0] atc_r, atc_nxt, kind_r, kind_nxt;
  logic apn_r, apn_nxt;
  logic [SW-1:0] kslot_r, kslot_nxt, eslot_r, eslot_nxt;
  logic [1:0] kring_r [RING_DEPTH];
  logic [1:0] ering_r [RING_DEPTH];

  logic [TIMER_BITS-1:0] ic, ec, pc;
  logic [DW-1:0] dlim, dlim_new, pcw, npw;
  logic signed [DW:0] win;
  logic [TIMER_BITS-1:0] npt, bpt, itt, sdt;
  logic [1:0] start, hk, ec_c;
  logic hw, ew, rst_p;
  logic [1:0] atc_inc;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if ({{(32-SW){1'b0}}, s} >= 32'(RING_DEPTH - 1)) r = '0;
    else r = s + SW'(1);
    return r;
  endfunction

  always_comb begin
    npt = TIMER_BITS'(cfg.normal_period);
    bpt = TIMER_BITS'(cfg.backup_period);
    itt = TIMER_BITS'(cfg.insp_time_ms);
    sdt = TIMER_BITS'(cfg.start_delay_ms);
    if (TIMER_BITS > 16) begin
      npt = TIMER_BITS'({16'd0, cfg.normal_period});
      bpt = TIMER_BITS'({16'd0, cfg.backup_period});
      itt = TIMER_BITS'({16'd0, cfg.insp_time_ms});
      sdt = TIMER_BITS'({16'd0, cfg.start_delay_ms});
    end
  end

  always_comb begin
    ic = (ic_r == TMAX) ? TMAX : ic_r + 1'b1;
    ec = (ec_r == TMAX) ? TMAX : ec_r + 1'b1;
    pc = (pc_r == TMAX) ? TMAX : pc_r + 1'b1;
    dlim = DW'(mark_r) + {1'b0, lti_r, 1'b0};
    dlim_new = DW'(pc) + {1'b0, ic, 1'b0};
    pcw = DW'(pc);
    npw = DW'(npt);
    win = $signed({1'b0, npw}) - $signed({1'b0, DW'(itt)});
    atc_inc = (atc_r < cfg.apnea_exit_triggers) ? atc_r + 2'd1 : atc_r;

    phase_nxt = phase_r; first_nxt = first_r; sup_seen_nxt = sup_seen_r;
    delayed_nxt = delayed_r; canc_nxt = canc_r; te_done_nxt = te_done_r;
    ic_nxt = ic; ec_nxt = ec; pc_nxt = pc; mark_nxt = mark_r;
    lti_nxt = lti_r; lte_nxt = lte_r; atc_nxt = atc_r;
    kind_nxt = kind_r; apn_nxt = apn_r;
    start = spbc_pkg::START_NONE; hk = spbc_pkg::HIST_SUPPORT;
    ec_c = spbc_pkg::END_TIMED; hw = 1'b0; ew = 1'b0; rst_p = 1'b0;

    case (phase_r)
      spbc_pkg::PH_START: begin
        if (!first_r) begin
          first_nxt = 1'b1; ec_nxt = '0; te_done_nxt = 1'b0;
          kind_nxt = spbc_pkg::KIND_ASSIST; apn_nxt = 1'b0; rst_p = 1'b1;
        end else if (din.insp_trigger || ec >= sdt) begin
          ic_nxt = '0; pc_nxt = '0; canc_nxt = 1'b0; te_done_nxt = 1'b1;
          apn_nxt = 1'b0; rst_p = 1'b1;
          if (din.insp_trigger) begin
            start = spbc_pkg::START_PAT; kind_nxt = spbc_pkg::KIND_ASSIST;
            phase_nxt = spbc_pkg::PH_MAND_TRIG;
          end else begin
            start = spbc_pkg::START_MACH; kind_nxt = spbc_pkg::KIND_CTRL;
            phase_nxt = spbc_pkg::PH_MAND_CTRL;
          end
        end
      end
      spbc_pkg::PH_EXH, spbc_pkg::PH_APNEA_EXH: begin
        if (phase_r == spbc_pkg::PH_EXH) begin
          if (din.insp_trigger) begin
            if ($signed({1'b0, pcw}) < win) begin
              start = spbc_pkg::START_PAT; te_done_nxt = 1'b1;
              kind_nxt = spbc_pkg::KIND_SUPPORT; apn_nxt = 1'b0;
              phase_nxt = spbc_pkg::PH_SUPPORT; sup_seen_nxt = 1'b1;
            end else if (pc < npt || (pcw < dlim && delayed_r)) begin
              start = spbc_pkg::START_PAT; te_done_nxt = 1'b1;
              kind_nxt = spbc_pkg::KIND_ASSIST; apn_nxt = 1'b0;
              phase_nxt = spbc_pkg::PH_MAND_TRIG;
              canc_nxt = 1'b1; delayed_nxt = 1'b0; hw = 1'b1;
              hk = sup_seen_r ? spbc_pkg::HIST_SUPPORT : spbc_pkg::HIST_TRIG;
              sup_seen_nxt = 1'b0;
            end
          end else if (!canc_r && ((pc >= npt && !delayed_r) ||
                                   (pcw >= dlim && delayed_r))) begin
            start = spbc_pkg::START_MACH; te_done_nxt = 1'b1;
            kind_nxt = spbc_pkg::KIND_CTRL; apn_nxt = 1'b0;
            phase_nxt = spbc_pkg::PH_MAND_CTRL; pc_nxt = '0;
            delayed_nxt = 1'b0; hw = 1'b1;
            hk = sup_seen_r ? spbc_pkg::HIST_SUPPORT : spbc_pkg::HIST_CTRL;
            sup_seen_nxt = 1'b0;
          end else if (canc_r && pc >= npt) begin
            pc_nxt = '0; canc_nxt = 1'b0;
          end else if (din.apnea_alarm) begin
            start = spbc_pkg::START_MACH; te_done_nxt = 1'b1;
            kind_nxt = spbc_pkg::KIND_CTRL; apn_nxt = 1'b1;
            phase_nxt = spbc_pkg::PH_APNEA_INSP; pc_nxt = '0;
            canc_nxt = 1'b0; delayed_nxt = 1'b0;
          end
        end else begin
          if (din.insp_trigger) begin
            if (pc < bpt) begin
              start = spbc_pkg::START_PAT; te_done_nxt = 1'b1;
              kind_nxt = spbc_pkg::KIND_ASSIST; apn_nxt = 1'b0;
              if (atc_inc >= cfg.apnea_exit_triggers) begin
                phase_nxt = spbc_pkg::PH_MAND_TRIG; atc_nxt = 2'd0;
              end else begin
                phase_nxt = spbc_pkg::PH_APNEA_INSP; atc_nxt = atc_inc;
              end
              pc_nxt = '0; canc_nxt = 1'b0; hw = 1'b1; hk = spbc_pkg::HIST_TRIG;
            end
          end else if (pc >= bpt) begin
            start = spbc_pkg::START_MACH; te_done_nxt = 1'b1;
            kind_nxt = spbc_pkg::KIND_CTRL; apn_nxt = 1'b1;
            phase_nxt = spbc_pkg::PH_APNEA_INSP; pc_nxt = '0;
            canc_nxt = 1'b0; hw = 1'b1; hk = spbc_pkg::HIST_CTRL; atc_nxt = 2'd0;
          end
        end
        if (te_done_nxt) begin
          lte_nxt = ec; ic_nxt = '0; rst_p = 1'b1;
        end
      end
      spbc_pkg::PH_MAND_TRIG, spbc_pkg::PH_MAND_CTRL, spbc_pkg::PH_APNEA_INSP: begin
        if (phase_r == spbc_pkg::PH_MAND_TRIG && pc >= npt) begin
          pc_nxt = '0; canc_nxt = 1'b0;
        end
        if (ic >= itt || din.high_pressure) begin
          lti_nxt = ic; ec_nxt = '0; te_done_nxt = 1'b0; mark_nxt = pc_nxt;
          phase_nxt = (phase_r == spbc_pkg::PH_APNEA_INSP) ?
                      spbc_pkg::PH_APNEA_EXH : spbc_pkg::PH_EXH;
        end
      end
      spbc_pkg::PH_SUPPORT: begin
        if ((din.exp_trigger && ic >= TIMER_BITS'(din.support_ti_min)) ||
            ic >= TIMER_BITS'(din.support_ti_max) || din.high_pressure) begin
          lti_nxt = ic; ec_nxt = '0; te_done_nxt = 1'b0; mark_nxt = pc;
          phase_nxt = spbc_pkg::PH_EXH;
          if (dlim_new >= npw) delayed_nxt = 1'b1;
          ew = 1'b1;
          ec_c = (ic >= TIMER_BITS'(din.support_ti_max)) ? spbc_pkg::END_TIMED :
                 (din.high_pressure ? spbc_pkg::END_HP : spbc_pkg::END_FLOW);
        end
      end
      default: phase_nxt = spbc_pkg::PH_OTHER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spbc_pkg::PH_START; first_r <= 1'b0; sup_seen_r <= 1'b0;
      delayed_r <= 1'b0; canc_r <= 1'b0; te_done_r <= 1'b0;
      ic_r <= '0; ec_r <= '0; pc_r <= '0; mark_r <= '0; lti_r <= '0; lte_r <= '0;
      atc_r <= '0; kind_r <= spbc_pkg::KIND_ASSIST; apn_r <= 1'b0;
      kslot_r <= '0; eslot_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt; first_r <= first_nxt; sup_seen_r <= sup_seen_nxt;
      delayed_r <= delayed_nxt; canc_r <= canc_nxt; te_done_r <= te_done_nxt;
      ic_r <= ic_nxt; ec_r <= ec_nxt; pc_r <= pc_nxt; mark_r <= mark_nxt;
      lti_r <= lti_nxt; lte_r <= lte_nxt; atc_r <= atc_nxt;
      kind_r <= kind_nxt; apn_r <= apn_nxt;
      if (hw) kslot_r <= kslot_nxt;
      if (ew) eslot_r <= eslot_nxt;
    end
  end

  assign kslot_nxt = slot_inc(kslot_r);
  assign eslot_nxt = slot_inc(eslot_r);

  always_ff @(posedge clk) begin
    if (step && hw) kring_r[kslot_r] <= hk;
    if (step && ew) ering_r[eslot_r] <= ec_c;
  end

  always_comb begin
    dout.breath_start = start;
    dout.phase_now = phase_nxt;
    dout.cycle_kind = kind_nxt;
    dout.apnea_controlled = apn_nxt;
    dout.ti_measured = (TIMER_BITS > 16 && (lti_nxt > TIMER_BITS'(16'hFFFF))) ?
                       16'hFFFF : 16'(lti_nxt);
    dout.te_measured = (TIMER_BITS > 16 && (lte_nxt > TIMER_BITS'(16'hFFFF))) ?
                       16'hFFFF : 16'(lte_nxt);
    dout.history_written = hw;
    dout.history_kind = hw ? hk : 2'd0;
    dout.support_end_written = ew;
    dout.support_end_cause = ew ? ec_c : 2'd0;
    dout.apnea_restart = rst_p;
  end

  logic unused_rings;
  assign unused_rings = ^{kring_r[0], ering_r[0], dlim[0]};
endmodule

### design/spbc_out_reg.sv
module spbc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  spbc_pkg::out_word_t din,
  output logic                full,
  spbc_out_if.source          out_ch
);
  logic valid_r;
  spbc_pkg::out_word_t data_r;

  assign full = valid_r && !out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.data = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (load) valid_r <= 1'b1;
    else if (out_ch.ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= din;
  end
endmodule

### design/simv_pressure_breath_cycler.sv
// Result: each accepted word's result is registered in the result register
// as it is accepted. Throughput: one word per cycle; input stalls only while
// the result register holds a word the sink has not taken.
// Reset: synchronous active-low rst_n clears sequencer state to start-up,
// loads the register defaults and empties the result register.
module simv_pressure_breath_cycler #(
  parameter int RING_DEPTH = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  spbc_in_if.sink      in_ch,
  spbc_out_if.source   out_ch,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  spbc_pkg::cfg_t cfg;
  spbc_pkg::out_word_t res;
  logic full, step;

  assign in_ch.ready = !full;
  assign step = in_ch.valid && !full;

  spbc_cfg_regs u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cfg(cfg)
  );

  spbc_seq #(.RING_DEPTH(RING_DEPTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .step(step), .din(in_ch.data), .cfg(cfg), .dout(res)
  );

  spbc_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .load(step), .din(res), .full(full), .out_ch(out_ch)
  );
endmodule

### design/spbc_checker.sv
`include "simv_pressure_breath_cycler_defines.svh"
module spbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input spbc_pkg::out_word_t out_data
);
  `SPBC_ASSERT_NXT(a_accept_gives_word, in_valid && in_ready, out_valid)
  `SPBC_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
  `SPBC_ASSERT_IMP(a_hist_kind_zero, out_valid && !out_data.history_written, out_data.history_kind == 2'd0)
  `SPBC_ASSERT_IMP(a_end_needs_exh, out_valid && out_data.support_end_written, out_data.phase_now == spbc_pkg::PH_EXH)
endmodule

bind simv_pressure_breath_cycler spbc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

### tb/simv_pressure_breath_cycler_tb.sv
`timescale 1ns / 100ps

module simv_pressure_breath_cycler_tb;
  import spbc_pkg::*;

  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  spbc_in_if in_ch();
  spbc_out_if out_ch();

  simv_pressure_breath_cycler DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sequencer copy
  logic [2:0]  seq_phase;
  bit          first_done, support_seen, mand_delayed, mand_cancelled, te_done;
  int unsigned insp_cnt, exh_cnt, period_cnt, exh_mark, last_ti, last_te;
  int unsigned trig_cnt;
  logic [1:0]  rec_kind;
  bit          rec_apnea;
  int unsigned normal_period, backup_period, insp_time, start_delay, exit_trigs;

  out_word_t   breath_q[$];
  dir_row_t    dir_rows[$];
  int unsigned accepted = 0;
  int          errors = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic int unsigned period_for(int unsigned rate);
    return 60000 / ((rate == 0) ? 1 : rate);
  endfunction

  function automatic int unsigned timer_inc(int unsigned c);
    return (c >= 65535) ? 65535 : c + 1;
  endfunction

  task automatic sequencer_step(input in_word_t w, output out_word_t r);
    logic [1:0] start_k, hist_k, end_c;
    bit hist_w, end_w, restart, timed;
    longint unsigned delay_lim;
    start_k = START_NONE;
    hist_k = HIST_SUPPORT;
    end_c = END_TIMED;
    hist_w = 0;
    end_w = 0;
    restart = 0;
    insp_cnt = timer_inc(insp_cnt);
    exh_cnt = timer_inc(exh_cnt);
    period_cnt = timer_inc(period_cnt);
    delay_lim = longint'(exh_mark) + 2 * longint'(last_ti);
    case (seq_phase)
      PH_START: begin
        if (!first_done) begin
          first_done = 1;
          exh_cnt = 0;
          te_done = 0;
          rec_kind = KIND_ASSIST;
          rec_apnea = 0;
          restart = 1;
        end else if (w.insp_trigger || exh_cnt >= start_delay) begin
          insp_cnt = 0;
          period_cnt = 0;
          mand_cancelled = 0;
          te_done = 1;
          rec_apnea = 0;
          restart = 1;
          if (w.insp_trigger) begin
            start_k = START_PAT;
            rec_kind = KIND_ASSIST;
            seq_phase = PH_MAND_TRIG;
          end else begin
            start_k = START_MACH;
            rec_kind = KIND_CTRL;
            seq_phase = PH_MAND_CTRL;
          end
        end
      end
      PH_EXH: begin
        if (w.insp_trigger) begin
          if (longint'(period_cnt) < longint'(normal_period) - longint'(insp_time)) begin
            start_k = START_PAT;
            te_done = 1;
            rec_kind = KIND_SUPPORT;
            rec_apnea = 0;
            seq_phase = PH_SUPPORT;
            support_seen = 1;
          end else if (period_cnt < normal_period ||
                       (period_cnt < delay_lim && mand_delayed)) begin
            start_k = START_PAT;
            te_done = 1;
            rec_kind = KIND_ASSIST;
            rec_apnea = 0;
            seq_phase = PH_MAND_TRIG;
            mand_cancelled = 1;
            mand_delayed = 0;
            hist_w = 1;
            hist_k = support_seen ? HIST_SUPPORT : HIST_TRIG;
            support_seen = 0;
          end
        end else if (!mand_cancelled &&
                     ((period_cnt >= normal_period && !mand_delayed) ||
                      (period_cnt >= delay_lim && mand_delayed))) begin
          start_k = START_MACH;
          te_done = 1;
          rec_kind = KIND_CTRL;
          rec_apnea = 0;
          seq_phase = PH_MAND_CTRL;
          period_cnt = 0;
          mand_delayed = 0;
          hist_w = 1;
          hist_k = support_seen ? HIST_SUPPORT : HIST_CTRL;
          support_seen = 0;
        end else if (mand_cancelled && period_cnt >= normal_period) begin
          period_cnt = 0;
          mand_cancelled = 0;
        end else if (w.apnea_alarm) begin
          start_k = START_MACH;
          te_done = 1;
          rec_kind = KIND_CTRL;
          rec_apnea = 1;
          seq_phase = PH_APNEA_INSP;
          period_cnt = 0;
          mand_cancelled = 0;
          mand_delayed = 0;
        end
        if (te_done) begin
          last_te = exh_cnt;
          insp_cnt = 0;
          restart = 1;
        end
      end
      PH_MAND_TRIG, PH_MAND_CTRL, PH_APNEA_INSP: begin
        if (seq_phase == PH_MAND_TRIG && period_cnt >= normal_period) begin
          period_cnt = 0;
          mand_cancelled = 0;
        end
        if (insp_cnt >= insp_time || w.high_pressure) begin
          last_ti = insp_cnt;
          exh_cnt = 0;
          te_done = 0;
          exh_mark = period_cnt;
          seq_phase = (seq_phase == PH_APNEA_INSP) ? PH_APNEA_EXH : PH_EXH;
        end
      end
      PH_SUPPORT: begin
        if ((w.exp_trigger && insp_cnt >= w.support_ti_min) ||
            insp_cnt >= w.support_ti_max || w.high_pressure) begin
          timed = insp_cnt >= w.support_ti_max;
          last_ti = insp_cnt;
          exh_cnt = 0;
          te_done = 0;
          exh_mark = period_cnt;
          seq_phase = PH_EXH;
          if (longint'(exh_mark) + 2 * longint'(last_ti) >= longint'(normal_period))
            mand_delayed = 1;
          end_w = 1;
          end_c = timed ? END_TIMED : (w.high_pressure ? END_HP : END_FLOW);
        end
      end
      PH_APNEA_EXH: begin
        if (w.insp_trigger) begin
          if (period_cnt < backup_period) begin
            start_k = START_PAT;
            te_done = 1;
            rec_kind = KIND_ASSIST;
            rec_apnea = 0;
            if (trig_cnt < exit_trigs) trig_cnt = (trig_cnt + 1) & 3;
            if (trig_cnt >= exit_trigs) begin
              seq_phase = PH_MAND_TRIG;
              trig_cnt = 0;
            end else begin
              seq_phase = PH_APNEA_INSP;
            end
            insp_cnt = 0;
            period_cnt = 0;
            mand_cancelled = 0;
            hist_w = 1;
            hist_k = HIST_TRIG;
          end
        end else if (period_cnt >= backup_period) begin
          start_k = START_MACH;
          te_done = 1;
          rec_kind = KIND_CTRL;
          rec_apnea = 1;
          seq_phase = PH_APNEA_INSP;
          period_cnt = 0;
          mand_cancelled = 0;
          hist_w = 1;
          hist_k = HIST_CTRL;
          trig_cnt = 0;
        end
        if (te_done) begin
          last_te = exh_cnt;
          insp_cnt = 0;
          restart = 1;
        end
      end
      default: seq_phase = PH_OTHER;
    endcase
    r.breath_start = start_k;
    r.phase_now = seq_phase;
    r.cycle_kind = rec_kind;
    r.apnea_controlled = rec_apnea;
    r.ti_measured = 16'(last_ti);
    r.te_measured = 16'(last_te);
    r.history_written = hist_w;
    r.history_kind = hist_w ? hist_k : 2'd0;
    r.support_end_written = end_w;
    r.support_end_cause = end_w ? end_c : 2'd0;
    r.apnea_restart = restart;
  endtask

  // accept and check
  always @(posedge clk) begin
    out_word_t want, got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (breath_q.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
      end else begin
        want = breath_q.pop_front();
        if (got.breath_start !== want.breath_start) begin
          $error("breath_start exp %0d got %0d", want.breath_start, got.breath_start); errors++;
        end
        if (got.phase_now !== want.phase_now) begin
          $error("phase_now exp %0d got %0d", want.phase_now, got.phase_now); errors++;
        end
        if (got.cycle_kind !== want.cycle_kind) begin
          $error("cycle_kind exp %0d got %0d", want.cycle_kind, got.cycle_kind); errors++;
        end
        if (got.apnea_controlled !== want.apnea_controlled) begin
          $error("apnea_controlled exp %0d got %0d", want.apnea_controlled,
                 got.apnea_controlled); errors++;
        end
        if (got.ti_measured !== want.ti_measured) begin
          $error("ti_measured exp %0d got %0d", want.ti_measured, got.ti_measured); errors++;
        end
        if (got.te_measured !== want.te_measured) begin
          $error("te_measured exp %0d got %0d", want.te_measured, got.te_measured); errors++;
        end
        if (got.history_written !== want.history_written) begin
          $error("history_written exp %0d got %0d", want.history_written,
                 got.history_written); errors++;
        end
        if (got.history_kind !== want.history_kind) begin
          $error("history_kind exp %0d got %0d", want.history_kind, got.history_kind); errors++;
        end
        if (got.support_end_written !== want.support_end_written) begin
          $error("support_end_written exp %0d got %0d", want.support_end_written,
                 got.support_end_written); errors++;
        end
        if (got.support_end_cause !== want.support_end_cause) begin
          $error("support_end_cause exp %0d got %0d", want.support_end_cause,
                 got.support_end_cause); errors++;
        end
        if (got.apnea_restart !== want.apnea_restart) begin
          $error("apnea_restart exp %0d got %0d", want.apnea_restart, got.apnea_restart);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sequencer_step(in_ch.data, want);
      if (accepted < dir_rows.size() && dir_rows[accepted].fixed)
        want = dir_rows[accepted].result;
      breath_q.push_back(want);
      accepted++;
    end
  end

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_CONTROL_RATE: normal_period = period_for(val[5:0]);
      REG_BACKUP_RATE:  backup_period = period_for(val[5:0]);
      REG_INSP_TIME:    insp_time = val[15:0];
      REG_START_DELAY:  start_delay = val[15:0];
      REG_APNEA_EXIT:   exit_trigs = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic apply_setting(input int unsigned crate, input int unsigned brate,
                               input int unsigned itime, input int unsigned sdelay,
                               input int unsigned ex);
    reg_write(REG_CONTROL_RATE, crate);
    reg_write(REG_BACKUP_RATE, brate);
    reg_write(REG_INSP_TIME, itime);
    reg_write(REG_START_DELAY, sdelay);
    reg_write(REG_APNEA_EXIT, ex);
  endtask

  task automatic send_word(input in_word_t w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain;
    while (breath_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic in_word_t tick_word();
    in_word_t w;
    if ($urandom_range(0, 9) == 0) begin
      w = in_word_t'({$urandom, $urandom});
    end else begin
      w.insp_trigger = $urandom_range(0, 29) == 0;
      w.exp_trigger = $urandom_range(0, 5) == 0;
      w.high_pressure = $urandom_range(0, 79) == 0;
      w.apnea_alarm = $urandom_range(0, 39) == 0;
      w.support_ti_min = $urandom_range(0, 20);
      w.support_ti_max = ($urandom_range(0, 19) == 0) ? 16'hffff : $urandom_range(0, 40);
    end
    return w;
  endfunction

  function automatic void add_row(input bit it, input bit et, input bit hp, input bit ap,
                                  input logic [15:0] tmin, input logic [15:0] tmax);
    dir_row_t row;
    row.word = '{it, et, hp, ap, tmin, tmax};
    row.fixed = 0;
    row.result = '0;
    dir_rows.push_back(row);
  endfunction

  initial begin
    out_word_t first_res;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    seq_phase = PH_START;
    {first_done, support_seen, mand_delayed, mand_cancelled, te_done} = '0;
    {insp_cnt, exh_cnt, period_cnt, exh_mark, last_ti, last_te, trig_cnt} = '0;
    rec_kind = KIND_ASSIST;
    rec_apnea = 0;
    normal_period = period_for(12);
    backup_period = period_for(12);
    insp_time = 1000;
    start_delay = 2000;
    exit_trigs = 2;

    add_row(0, 0, 0, 0, 16'd0, 16'd0);
    add_row(1, 0, 0, 0, 16'd0, 16'd0);
    first_res = '0;
    first_res.apnea_restart = 1'b1;
    dir_rows[0].fixed = 1;
    dir_rows[0].result = first_res;
    first_res.breath_start = START_PAT;
    first_res.phase_now = PH_MAND_TRIG;
    dir_rows[1].fixed = 1;
    dir_rows[1].result = first_res;
    add_row(0, 0, 1, 0, 16'd0, 16'hffff);
    add_row(1, 0, 0, 0, 16'd0, 16'hffff);
    add_row(0, 1, 0, 0, 16'd0, 16'hffff);
    add_row(1, 0, 0, 0, 16'd0, 16'hffff);
    add_row(0, 0, 1, 0, 16'hffff, 16'hffff);
    add_row(1, 0, 0, 0, 16'd0, 16'd0);
    add_row(0, 0, 0, 0, 16'd0, 16'd0);
    add_row(1, 1, 1, 1, 16'hffff, 16'hffff);
    add_row(0, 1, 1, 0, 16'hffff, 16'hffff);
    add_row(0, 0, 0, 1, 16'd0, 16'd0);
    add_row(0, 0, 0, 0, 16'd0, 16'd0);
    add_row(0, 0, 0, 0, 16'd0, 16'd0);
    add_row(0, 0, 1, 0, 16'd0, 16'd0);
    add_row(1, 0, 0, 1, 16'd0, 16'd0);
    add_row(0, 0, 1, 0, 16'd0, 16'd0);
    add_row(1, 0, 0, 0, 16'd0, 16'd0);
    add_row(0, 0, 1, 0, 16'd0, 16'd0);
    add_row(0, 0, 0, 1, 16'd0, 16'd0);
    add_row(0, 0, 1, 0, 16'd0, 16'd0);
    add_row(1, 0, 0, 0, 16'd0, 16'd0);
    add_row(0, 1, 0, 0, 16'h5555, 16'haaaa);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    apply_setting(60, 63, 3, 4, 1);
    foreach (dir_rows[i]) send_word(dir_rows[i].word);
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: apply_setting(63, 60, 10, 0, 2);
        1: apply_setting(0, 0, 5, 20, 3);
        2: apply_setting(40, 1, 2000, 65535, 0);
        3: apply_setting(12, 12, 1000, 2000, 2);
        default: begin
          apply_setting(63, 63, 0, 1, 1);
          calm = 1'b1;
        end
      endcase
      if (ph == 3) hold_req = 1'b1;
      repeat (220) send_word(tick_word());
      in_ch.valid <= 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
